[src/tcch_pkg.sv]
package tcch_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam int ATAN_TAB_LEN = 24;

    localparam int VEC_W     = 52;
    localparam int Z_W       = 21;
    localparam int TRIG_W    = 17;
    localparam int MAC_A_W   = 40;
    localparam int MAC_ACC_W = 56;
    localparam int MAC_BITS  = TRIG_W;
    localparam int MAC_CNT_W = $clog2(MAC_BITS);

    localparam int ANG_PI      = 205887;
    localparam int ANG_HALF_PI = 102944;
    localparam int GAIN_Q30    = 652032874;
    localparam int DECL_MUL    = 585635;
    localparam int PI_Q13      = 25736;
    localparam int TWO_PI_Q13  = 51472;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DECLINATION = 3'd3;

    localparam int ATAN_TAB [ATAN_TAB_LEN] = '{
        51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2,
        1, 0, 0, 0, 0, 0, 0, 0
    };

    typedef enum logic {
        CORDIC_ROTATE,
        CORDIC_VECTOR
    } cordic_mode_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_status_t;

    function automatic logic signed [Z_W-1:0] atan_at(input logic [4:0] i);
        logic signed [Z_W-1:0] r;
        r = '0;
        if (int'(i) < ATAN_TAB_LEN)
        begin
            r = Z_W'(ATAN_TAB[i]);
        end
        return r;
    endfunction

endpackage

[src/tcch_mac.sv]
module tcch_mac (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    input  logic                                    clear,
    input  logic signed [tcch_pkg::MAC_A_W-1:0]     a,
    input  logic signed [tcch_pkg::TRIG_W-1:0]      b,
    output tcch_pkg::unit_status_t                  status,
    output logic signed [tcch_pkg::MAC_ACC_W-1:0]   acc
);
    import tcch_pkg::*;

    logic signed [MAC_ACC_W-1:0] acc_reg, acc_next;
    logic signed [MAC_ACC_W-1:0] a_reg;
    logic        [TRIG_W-1:0]    b_reg;
    logic        [MAC_CNT_W-1:0] cnt_reg;
    logic                        busy_reg, done_reg;
    logic                        last;

    assign last = (cnt_reg == MAC_CNT_W'(MAC_BITS - 1));

    // sign bit of b carries negative weight
    always_comb
    begin
        acc_next = acc_reg;
        if (b_reg[0])
        begin
            acc_next = last ? (acc_reg - a_reg) : (acc_reg + a_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            a_reg    <= '0;
            b_reg    <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                if (clear)
                begin
                    acc_reg <= '0;
                end
                a_reg    <= {{(MAC_ACC_W-MAC_A_W){a[MAC_A_W-1]}}, a};
                b_reg    <= b;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                acc_reg <= acc_next;
                a_reg   <= a_reg <<< 1;
                b_reg   <= b_reg >> 1;
                cnt_reg <= cnt_reg + 1'b1;
                if (last)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign acc         = acc_reg;

endmodule

[src/tcch_cordic.sv]
module tcch_cordic (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  tcch_pkg::cordic_mode_t                mode,
    input  logic signed [15:0]                    angle,
    input  logic signed [tcch_pkg::VEC_W-1:0]     vec_x,
    input  logic signed [tcch_pkg::VEC_W-1:0]     vec_y,
    output tcch_pkg::unit_status_t                status,
    output logic signed [tcch_pkg::TRIG_W-1:0]    cos_q15,
    output logic signed [tcch_pkg::TRIG_W-1:0]    sin_q15,
    output logic signed [tcch_pkg::Z_W-1:0]       angle_q16
);
    import tcch_pkg::*;

    logic signed [VEC_W-1:0] x_reg, y_reg, x_next, y_next;
    logic signed [Z_W-1:0]   z_reg, z_next;
    logic signed [VEC_W-1:0] dx, dy;
    logic signed [Z_W-1:0]   at, z_in;
    logic [STEP_W-1:0]       cnt_reg;
    cordic_mode_t            mode_reg;
    logic                    neg_reg, zero_reg, busy_reg, done_reg;
    logic signed [VEC_W-1:0] x_rnd, y_rnd;
    logic signed [TRIG_W-1:0] c_abs, s_abs;

    assign z_in = {{(Z_W-19){angle[15]}}, angle, 3'b000};
    assign dx   = y_reg >>> cnt_reg;
    assign dy   = x_reg >>> cnt_reg;
    assign at   = atan_at(5'(cnt_reg));

    always_comb
    begin
        if (mode_reg == CORDIC_ROTATE)
        begin
            if (!z_reg[Z_W-1])
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - at;
            end
            else
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + at;
            end
        end
        else
        begin
            if (!y_reg[VEC_W-1] && (y_reg != '0))
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + at;
            end
            else
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - at;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg    <= '0;
            y_reg    <= '0;
            z_reg    <= '0;
            cnt_reg  <= '0;
            mode_reg <= CORDIC_ROTATE;
            neg_reg  <= 1'b0;
            zero_reg <= 1'b0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                mode_reg <= mode;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
                neg_reg  <= 1'b0;
                zero_reg <= 1'b0;
                if (mode == CORDIC_ROTATE)
                begin
                    x_reg <= VEC_W'(GAIN_Q30);
                    y_reg <= '0;
                    // fold angles beyond a quarter turn, negate the results later
                    if (z_in > ANG_HALF_PI)
                    begin
                        z_reg   <= z_in - Z_W'(ANG_PI);
                        neg_reg <= 1'b1;
                    end
                    else if (z_in < -ANG_HALF_PI)
                    begin
                        z_reg   <= z_in + Z_W'(ANG_PI);
                        neg_reg <= 1'b1;
                    end
                    else
                    begin
                        z_reg <= z_in;
                    end
                end
                else
                begin
                    zero_reg <= (vec_x == '0) && (vec_y == '0);
                    if (vec_x[VEC_W-1])
                    begin
                        if (!vec_y[VEC_W-1])
                        begin
                            x_reg <= vec_y;
                            y_reg <= -vec_x;
                            z_reg <= Z_W'(ANG_HALF_PI);
                        end
                        else
                        begin
                            x_reg <= -vec_y;
                            y_reg <= vec_x;
                            z_reg <= -Z_W'(ANG_HALF_PI);
                        end
                    end
                    else
                    begin
                        x_reg <= vec_x;
                        y_reg <= vec_y;
                        z_reg <= '0;
                    end
                end
            end
            else if (busy_reg)
            begin
                x_reg   <= x_next;
                y_reg   <= y_next;
                z_reg   <= z_next;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(CORDIC_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign x_rnd = (x_reg + VEC_W'(16384)) >>> 15;
    assign y_rnd = (y_reg + VEC_W'(16384)) >>> 15;
    assign c_abs = x_rnd[TRIG_W-1:0];
    assign s_abs = y_rnd[TRIG_W-1:0];

    assign cos_q15     = neg_reg ? -c_abs : c_abs;
    assign sin_q15     = neg_reg ? -s_abs : s_abs;
    assign angle_q16   = zero_reg ? '0 : z_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

[src/tilt_compensated_compass_heading_core.sv]
// Tilt-compensated compass heading.
// Sample channel: sample_valid/sample_ready carry three raw magnetometer
// words, a completeness flag and roll and pitch (Q3.13 rad). A beat is taken
// when both are high. A complete sample reloads the held, offset-corrected
// axes; an incomplete one keeps them.
// Result channel: result_valid/result_ready carry heading_out (Q3.13 rad in
// (-pi, pi]) and the axes used for that sample.
// Config: cfg_write with cfg_addr and cfg_data writes offset_x, offset_y,
// offset_z or declination (1/128 degree); other indices drop.
// One sample at a time: a new sample is taken only once the previous result
// has left the last stage for the output register.
// Two CORDIC rotations and one vectoring pass run on a shared iterative
// CORDIC unit, one step a cycle; seven products run on a bit-serial
// multiply-accumulate unit, one multiplier bit a cycle.
// A finished result sits in the output register; the next sample is taken
// while it waits. If the receiver stalls with a result still pending, the
// next result holds in the last stage until the register frees.
// Reset clears the registers, held axes and all control state.
module tilt_compensated_compass_heading_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  sample_valid,
    output logic                                  sample_ready,
    input  logic signed [15:0]                    raw_first,
    input  logic signed [15:0]                    raw_middle,
    input  logic signed [15:0]                    raw_last,
    input  logic                                  sample_complete,
    input  logic signed [15:0]                    roll,
    input  logic signed [15:0]                    pitch,
    output logic                                  result_valid,
    input  logic                                  result_ready,
    output logic signed [15:0]                    heading_out,
    output logic signed [15:0]                    axis_x,
    output logic signed [15:0]                    axis_y,
    output logic signed [15:0]                    axis_z,
    input  logic                                  cfg_write,
    input  logic [tcch_pkg::CFG_IDX_W-1:0]        cfg_addr,
    input  logic [15:0]                           cfg_data
);
    import tcch_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROLL,
        S_PITCH,
        S_MAC,
        S_VEC,
        S_OUT
    } state_t;

    localparam logic [2:0] MAC_MY_SR = 3'd0;
    localparam logic [2:0] MAC_MZ_CR = 3'd1;
    localparam logic [2:0] MAC_T_SP  = 3'd2;
    localparam logic [2:0] MAC_MX_CP = 3'd3;
    localparam logic [2:0] MAC_MY_CR = 3'd4;
    localparam logic [2:0] MAC_MZ_SR = 3'd5;
    localparam logic [2:0] MAC_DECL  = 3'd6;

    state_t state_reg;
    logic [2:0] step_reg;
    logic kick_reg;

    logic [15:0] off_x_reg, off_y_reg, off_z_reg, decl_reg;
    logic signed [15:0] held_x_reg, held_y_reg, held_z_reg;
    logic signed [15:0] roll_reg, pitch_reg;
    logic signed [TRIG_W-1:0] cr_reg, sr_reg, cp_reg, sp_reg;
    logic signed [MAC_A_W-1:0] t_reg;
    logic signed [VEC_W-1:0] hx_reg, hy_neg_reg;
    logic signed [Z_W-1:0] dq_reg;
    logic signed [15:0] heading_pend_reg;
    logic signed [15:0] heading_out_reg, axis_x_reg, axis_y_reg, axis_z_reg;
    logic result_valid_reg;

    unit_status_t cor_st, mac_st;
    cordic_mode_t cor_mode;
    logic signed [15:0] cor_angle;
    logic signed [TRIG_W-1:0] cor_cos, cor_sin;
    logic signed [Z_W-1:0] cor_z;
    logic mac_clear;
    logic signed [MAC_A_W-1:0] mac_a;
    logic signed [TRIG_W-1:0] mac_b;
    logic signed [MAC_ACC_W-1:0] mac_acc;

    logic signed [MAC_A_W-1:0] ext_x, ext_y, ext_z;
    logic signed [MAC_ACC_W-1:0] dq_full;
    logic signed [VEC_W-1:0] hy_full;
    logic signed [Z_W+1:0] sum, h_raw, h_wrap;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_x_reg <= '0;
            off_y_reg <= '0;
            off_z_reg <= '0;
            decl_reg  <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_addr)
                REG_OFFSET_X:    off_x_reg <= cfg_data;
                REG_OFFSET_Y:    off_y_reg <= cfg_data;
                REG_OFFSET_Z:    off_z_reg <= cfg_data;
                REG_DECLINATION: decl_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign ext_x = {{(MAC_A_W-16){held_x_reg[15]}}, held_x_reg};
    assign ext_y = {{(MAC_A_W-16){held_y_reg[15]}}, held_y_reg};
    assign ext_z = {{(MAC_A_W-16){held_z_reg[15]}}, held_z_reg};

    // HX = sp*(my*sr + mz*cr) + (mx<<15)*cp ; HY = (my*cr - mz*sr) << 15
    always_comb
    begin
        mac_clear = 1'b0;
        mac_a     = '0;
        mac_b     = '0;
        unique case (step_reg)
            MAC_MY_SR:
            begin
                mac_clear = 1'b1;
                mac_a     = ext_y;
                mac_b     = sr_reg;
            end
            MAC_MZ_CR:
            begin
                mac_a = ext_z;
                mac_b = cr_reg;
            end
            MAC_T_SP:
            begin
                mac_clear = 1'b1;
                mac_a     = t_reg;
                mac_b     = sp_reg;
            end
            MAC_MX_CP:
            begin
                mac_a = ext_x <<< 15;
                mac_b = cp_reg;
            end
            MAC_MY_CR:
            begin
                mac_clear = 1'b1;
                mac_a     = ext_y;
                mac_b     = cr_reg;
            end
            MAC_MZ_SR:
            begin
                mac_a = -ext_z;
                mac_b = sr_reg;
            end
            MAC_DECL:
            begin
                mac_clear = 1'b1;
                mac_a     = MAC_A_W'(DECL_MUL);
                mac_b     = {decl_reg[15], decl_reg};
            end
            default:
            begin
                mac_clear = 1'b1;
            end
        endcase
    end

    assign cor_mode  = (state_reg == S_VEC) ? CORDIC_VECTOR : CORDIC_ROTATE;
    assign cor_angle = (state_reg == S_ROLL) ? roll_reg : pitch_reg;

    tcch_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (kick_reg && (state_reg != S_MAC)),
        .mode      (cor_mode),
        .angle     (cor_angle),
        .vec_x     (hx_reg),
        .vec_y     (hy_neg_reg),
        .status    (cor_st),
        .cos_q15   (cor_cos),
        .sin_q15   (cor_sin),
        .angle_q16 (cor_z)
    );

    tcch_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (kick_reg && (state_reg == S_MAC)),
        .clear  (mac_clear),
        .a      (mac_a),
        .b      (mac_b),
        .status (mac_st),
        .acc    (mac_acc)
    );

    assign dq_full = (mac_acc + MAC_ACC_W'(32768)) >>> 16;
    assign hy_full = {mac_acc[VEC_W-16:0], 15'b0};

    always_comb
    begin
        sum   = {{2{cor_z[Z_W-1]}}, cor_z} + {{2{dq_reg[Z_W-1]}}, dq_reg};
        h_raw = (sum + (Z_W+2)'(4)) >>> 3;
        if (h_raw > PI_Q13)
        begin
            h_wrap = h_raw - (Z_W+2)'(TWO_PI_Q13);
        end
        else if (h_raw <= -PI_Q13)
        begin
            h_wrap = h_raw + (Z_W+2)'(TWO_PI_Q13);
        end
        else
        begin
            h_wrap = h_raw;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            step_reg         <= MAC_MY_SR;
            kick_reg         <= 1'b0;
            held_x_reg       <= '0;
            held_y_reg       <= '0;
            held_z_reg       <= '0;
            roll_reg         <= '0;
            pitch_reg        <= '0;
            cr_reg           <= '0;
            sr_reg           <= '0;
            cp_reg           <= '0;
            sp_reg           <= '0;
            t_reg            <= '0;
            hx_reg           <= '0;
            hy_neg_reg       <= '0;
            dq_reg           <= '0;
            heading_pend_reg <= '0;
            heading_out_reg  <= '0;
            axis_x_reg       <= '0;
            axis_y_reg       <= '0;
            axis_z_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            kick_reg <= 1'b0;
            if (result_ready && (state_reg != S_OUT))
            begin
                result_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (sample_valid)
                    begin
                        roll_reg  <= roll;
                        pitch_reg <= pitch;
                        if (sample_complete)
                        begin
                            held_y_reg <= raw_first - off_y_reg;
                            held_z_reg <= raw_middle - off_z_reg;
                            held_x_reg <= (16'd0 - raw_last) - off_x_reg;
                        end
                        state_reg <= S_ROLL;
                        kick_reg  <= 1'b1;
                    end
                end
                S_ROLL:
                begin
                    if (cor_st.done)
                    begin
                        cr_reg    <= cor_cos;
                        sr_reg    <= cor_sin;
                        state_reg <= S_PITCH;
                        kick_reg  <= 1'b1;
                    end
                end
                S_PITCH:
                begin
                    if (cor_st.done)
                    begin
                        cp_reg    <= cor_cos;
                        sp_reg    <= cor_sin;
                        step_reg  <= MAC_MY_SR;
                        state_reg <= S_MAC;
                        kick_reg  <= 1'b1;
                    end
                end
                S_MAC:
                begin
                    if (mac_st.done)
                    begin
                        case (step_reg)
                            MAC_MZ_CR: t_reg      <= mac_acc[MAC_A_W-1:0];
                            MAC_MX_CP: hx_reg     <= mac_acc[VEC_W-1:0];
                            MAC_MZ_SR: hy_neg_reg <= -hy_full;
                            MAC_DECL:  dq_reg     <= dq_full[Z_W-1:0];
                            default:   ;
                        endcase
                        kick_reg <= 1'b1;
                        step_reg <= step_reg + 1'b1;
                        if (step_reg == MAC_DECL)
                        begin
                            state_reg <= S_VEC;
                        end
                    end
                end
                S_VEC:
                begin
                    if (cor_st.done)
                    begin
                        heading_pend_reg <= h_wrap[15:0];
                        state_reg        <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    // hold until the output register is free
                    if (!result_valid_reg || result_ready)
                    begin
                        heading_out_reg  <= heading_pend_reg;
                        axis_x_reg       <= held_x_reg;
                        axis_y_reg       <= held_y_reg;
                        axis_z_reg       <= held_z_reg;
                        result_valid_reg <= 1'b1;
                        state_reg        <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign sample_ready = (state_reg == S_IDLE);
    assign result_valid = result_valid_reg;
    assign heading_out  = heading_out_reg;
    assign axis_x       = axis_x_reg;
    assign axis_y       = axis_y_reg;
    assign axis_z       = axis_z_reg;

`ifndef SYNTHESIS
    a_idle_units_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        sample_ready |-> !cor_st.busy && !mac_st.busy)
        else $error("arithmetic unit busy while taking a sample");

    a_single_done: assert property (@(posedge clk) disable iff (!rst_n)
        !(cor_st.done && mac_st.done))
        else $error("both units finished in the same cycle");

    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (heading_out <= PI_Q13) && (heading_out > -PI_Q13))
        else $error("heading outside (-pi, pi]");

    a_mac_only_in_mac: assert property (@(posedge clk) disable iff (!rst_n)
        mac_st.busy |-> state_reg == S_MAC)
        else $error("multiplier running outside the product phase");
`endif

endmodule

[test/tb_tilt_compensated_compass_heading_core.sv]
`timescale 1ns / 1ps

module tb_tilt_compensated_compass_heading_core;
    import tcch_pkg::*;

    localparam int LATENCY = 3 * CORDIC_STEPS + 140;

    typedef struct packed {
        logic signed [15:0] first;
        logic signed [15:0] middle;
        logic signed [15:0] last;
        logic               complete;
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
    } sample_t;

    typedef struct packed {
        logic signed [15:0] heading;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
    } heading_t;

    logic clk;
    logic rst_n;
    logic sample_valid;
    logic sample_ready;
    logic signed [15:0] raw_first;
    logic signed [15:0] raw_middle;
    logic signed [15:0] raw_last;
    logic sample_complete;
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic result_valid;
    logic result_ready;
    logic signed [15:0] heading_out;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic cfg_write;
    logic [CFG_IDX_W-1:0] cfg_addr;
    logic [15:0] cfg_data;

    tilt_compensated_compass_heading_core uut (
        .clk(clk), .rst_n(rst_n),
        .sample_valid(sample_valid), .sample_ready(sample_ready),
        .raw_first(raw_first), .raw_middle(raw_middle), .raw_last(raw_last),
        .sample_complete(sample_complete), .roll(roll), .pitch(pitch),
        .result_valid(result_valid), .result_ready(result_ready),
        .heading_out(heading_out), .axis_x(axis_x), .axis_y(axis_y),
        .axis_z(axis_z),
        .cfg_write(cfg_write), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
    );

    // predictor state
    logic [15:0] off_x, off_y, off_z, decl;
    logic [15:0] hold_x, hold_y, hold_z;
    heading_t expected_headings[$];

    int send_idle_pct;
    int recv_idle_pct;
    int recv_hold_cycles;
    int mismatches;
    bit failed;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic longint sra(input longint v, input int n);
        return v >>> n;
    endfunction

    function automatic int atan_step(input int i);
        int tab [24] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                         256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0};
        return (i < 24) ? tab[i] : 0;
    endfunction

    task automatic trig_q15(input logic signed [15:0] a13, output longint c,
                            output longint s);
        int z;
        bit flip;
        longint x, y, dx, dy;
        z = int'(a13) * 8;
        flip = 1'b0;
        x = 64'sd652032874;
        y = 0;
        if (z > 102944)
        begin
            z -= 205887;
            flip = 1'b1;
        end
        else if (z < -102944)
        begin
            z += 205887;
            flip = 1'b1;
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            dx = sra(y, i);
            dy = sra(x, i);
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= atan_step(i);
            end
            else
            begin
                x += dx;
                y -= dy;
                z += atan_step(i);
            end
        end
        x = sra(x + 16384, 15);
        y = sra(y + 16384, 15);
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        c = x;
        s = y;
    endtask

    function automatic int bearing_q16(input longint yv, input longint xv);
        longint x, y, t, dx, dy;
        int z;
        x = xv;
        y = yv;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y;
                y = -t;
                z = 102944;
            end
            else
            begin
                x = -y;
                y = t;
                z = -102944;
            end
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            dx = sra(y, i);
            dy = sra(x, i);
            if (y > 0)
            begin
                x += dx;
                y -= dy;
                z += atan_step(i);
            end
            else
            begin
                x -= dx;
                y += dy;
                z -= atan_step(i);
            end
        end
        return z;
    endfunction

    task automatic predict_heading(input sample_t s);
        longint cr, sr, cp, sp, mx, my, mz, hx, hy, dq, sum;
        int h;
        heading_t r;
        if (s.complete)
        begin
            hold_y = s.first - off_y;
            hold_z = s.middle - off_z;
            hold_x = (16'd0 - s.last) - off_x;
        end
        mx = longint'($signed(hold_x));
        my = longint'($signed(hold_y));
        mz = longint'($signed(hold_z));
        trig_q15(s.roll, cr, sr);
        trig_q15(s.pitch, cp, sp);
        hx = mx * cp * 32768 + my * (sr * sp) + mz * (cr * sp);
        hy = (my * cr - mz * sr) * 32768;
        dq = sra(longint'($signed(decl)) * 585635 + 32768, 16);
        sum = longint'(bearing_q16(-hy, hx)) + dq;
        h = int'(sra(sum + 4, 3));
        if (h > PI_Q13)
            h -= TWO_PI_Q13;
        else if (h <= -PI_Q13)
            h += TWO_PI_Q13;
        r.heading = h[15:0];
        r.ax = hold_x;
        r.ay = hold_y;
        r.az = hold_z;
        expected_headings.push_back(r);
    endtask

    task automatic send_sample(input sample_t s);
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct)
            @(negedge clk);
        sample_valid <= 1'b1;
        raw_first <= s.first;
        raw_middle <= s.middle;
        raw_last <= s.last;
        sample_complete <= s.complete;
        roll <= s.roll;
        pitch <= s.pitch;
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
        predict_heading(s);
        @(negedge clk);
        sample_valid <= 1'b0;
        @(negedge clk);
    endtask

    // receiver: decide ready at each falling edge
    always @(negedge clk)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else if (recv_hold_cycles > 0)
        begin
            recv_hold_cycles <= recv_hold_cycles - 1;
            result_ready <= 1'b0;
        end
        else
            result_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        heading_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_headings.size() == 0)
            begin
                failed = 1'b1;
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: heading %0d", heading_out);
            end
            else
            begin
                want = expected_headings.pop_front();
                if (want.heading !== heading_out || want.ax !== axis_x
                    || want.ay !== axis_y || want.az !== axis_z)
                begin
                    failed = 1'b1;
                    mismatches++;
                    if (mismatches <= 10)
                        $display(
                            "mismatch: exp h=%0d x=%0d y=%0d z=%0d got h=%0d x=%0d y=%0d z=%0d",
                            want.heading, want.ax, want.ay, want.az,
                            heading_out, axis_x, axis_y, axis_z);
                end
            end
        end
    end

    task automatic drain();
        while (expected_headings.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 20) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] v);
        cfg_write <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= v;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_OFFSET_X: off_x = v;
            REG_OFFSET_Y: off_y = v;
            REG_OFFSET_Z: off_z = v;
            REG_DECLINATION: decl = v;
            default: ;
        endcase
        @(negedge clk);
    endtask

    function automatic sample_t random_sample();
        sample_t s;
        s.first = 16'($urandom);
        s.middle = 16'($urandom);
        s.last = 16'($urandom);
        s.complete = ($urandom_range(9, 0) != 0);
        if ($urandom_range(9, 0) == 0)
        begin
            s.roll = 16'($urandom);
            s.pitch = 16'($urandom);
        end
        else
        begin
            s.roll = 16'($urandom_range(51472, 0) - 25736);
            s.pitch = 16'($urandom_range(51472, 0) - 25736);
        end
        return s;
    endfunction

    task automatic test_directed();
        logic signed [15:0] angs [8] = '{16'sd0, 16'sd25736, -16'sd25736, 16'sd12868,
                                         -16'sd12868, 16'sh7fff, 16'sh8000, 16'sd12869};
        sample_t s;
        // zero field first
        s = '0;
        s.complete = 1'b1;
        send_sample(s);
        for (int i = 0; i < 8; i++)
        begin
            s.first = (i[0]) ? 16'sh7fff : 16'sh8000;
            s.middle = (i[1]) ? 16'sh8000 : 16'sh7fff;
            s.last = (i[2]) ? 16'sh7fff : -16'sd1;
            s.complete = 1'b1;
            s.roll = angs[i];
            s.pitch = angs[7 - i];
            send_sample(s);
        end
        s = '0;
        s.first = 16'sd1000;
        s.last = -16'sd500;
        s.complete = 1'b1;
        send_sample(s);
        s.first = 16'sd123;
        s.complete = 1'b0;
        send_sample(s);
        s.last = 16'sd300;
        s.first = -16'sd300;
        s.complete = 1'b1;
        send_sample(s);
        drain();
    endtask

    task automatic test_random(input int n);
        for (int i = 0; i < n; i++)
            send_sample(random_sample());
        drain();
    endtask

    task automatic test_config_extremes();
        write_reg(REG_OFFSET_X, 16'h8000);
        write_reg(REG_OFFSET_Y, 16'h7fff);
        write_reg(REG_OFFSET_Z, 16'h8000);
        write_reg(REG_DECLINATION, 16'sd23040);
        test_random(40);
        write_reg(REG_OFFSET_X, 16'h7fff);
        write_reg(REG_OFFSET_Y, 16'h8000);
        write_reg(REG_OFFSET_Z, 16'h7fff);
        write_reg(REG_DECLINATION, -16'sd23040);
        test_random(40);
        write_reg(REG_DECLINATION, 16'h7fff);
        test_random(20);
        write_reg(REG_DECLINATION, 16'h8000);
        write_reg(3'd5, 16'h1234);
        write_reg(3'd7, 16'hffff);
        test_random(20);
        write_reg(REG_OFFSET_X, 16'($urandom));
        write_reg(REG_OFFSET_Y, 16'($urandom));
        write_reg(REG_OFFSET_Z, 16'($urandom));
        write_reg(REG_DECLINATION, 16'($urandom_range(46080, 0) - 23040));
    endtask

    task automatic test_backpressure();
        // stall the receiver long enough that the block backs up
        recv_hold_cycles = 3 * LATENCY;
        for (int i = 0; i < 6; i++)
            send_sample(random_sample());
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        sample_valid = 1'b0;
        raw_first = '0;
        raw_middle = '0;
        raw_last = '0;
        sample_complete = 1'b0;
        roll = '0;
        pitch = '0;
        result_ready = 1'b0;
        cfg_write = 1'b0;
        cfg_addr = '0;
        cfg_data = '0;
        off_x = '0;
        off_y = '0;
        off_z = '0;
        decl = '0;
        hold_x = '0;
        hold_y = '0;
        hold_z = '0;
        send_idle_pct = 6;
        recv_idle_pct = 70;
        recv_hold_cycles = 0;
        mismatches = 0;
        failed = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_config_extremes();
        test_random(450);
        send_idle_pct = 70;
        recv_idle_pct = 6;
        test_backpressure();
        test_random(450);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(450);

        if (!failed)
            $display("tb_tilt_compensated_compass_heading_core: clean");
        else
            $display("tb_tilt_compensated_compass_heading_core: errors");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("tb_tilt_compensated_compass_heading_core: errors");
        $finish;
    end

endmodule
